// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/mata_pkg.sv =====
// ----------------------------------------------------------------------------
// mata_pkg
// Shared constants, codes and types of the multi-ant torus automaton.
// ----------------------------------------------------------------------------
package mata_pkg;

  // Default sizes
  localparam int NUM_ANTS_DEF   = 3;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Register reset values
  localparam int RESET_WIDTH  = 20;
  localparam int RESET_HEIGHT = 10;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int ANT_W     = 3;
  localparam int COORD_W   = 6;
  localparam int HEAD_W    = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PLACE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // Heading codes
  localparam logic [HEAD_W-1:0] HD_POS_X = 2'd0;
  localparam logic [HEAD_W-1:0] HD_NEG_Y = 2'd1;
  localparam logic [HEAD_W-1:0] HD_NEG_X = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WB
  } state_e;

endpackage

// ===== design/multi_ant_torus_automaton.sv =====
// ----------------------------------------------------------------------------
// multi_ant_torus_automaton
// Several ants walking a wrap-around bit grid held in a row-wide memory.
// ----------------------------------------------------------------------------
// Sequence: an accepted command passes the read state, then the write-back
//   state; the result word is registered from write-back. A step walks the
//   ants from 0 in order; each ant is one read and one write-back of the row
//   memory port. No new command is taken until the sequencer is idle again.
// Reset: row valid flops clear the whole grid at once, no clearing pass; ants
//   go to (0,0) heading 0, width 20, height 10. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_ant_torus_automaton
  import mata_pkg::*;
#(
  parameter int NUM_ANTS   = NUM_ANTS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [ANT_W-1:0]     ant_sel_i,
  input  logic [COORD_W-1:0]   pos_x_i,
  input  logic [COORD_W-1:0]   pos_y_i,
  input  logic [HEAD_W-1:0]    heading_in_i,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // result channel
  output logic                 result_valid_o,
  output logic [ANT_W-1:0]     ant_id_o,
  output logic [COORD_W-1:0]   out_x_o,
  output logic [COORD_W-1:0]   out_y_o,
  output logic [HEAD_W-1:0]    out_heading_o,
  output logic                 cell_value_o,
  output logic                 last_o
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (NUM_ANTS > 1) ? $clog2(NUM_ANTS) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] grid_width_q, grid_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_W'(RESET_WIDTH);
      grid_height_q <= CFG_W'(RESET_HEIGHT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective grid size, clamped to 1..max
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (grid_width_q == '0)                 eff_w = WW'(1);
    else if (32'(grid_width_q) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else                                    eff_w = WW'(grid_width_q);
    if (grid_height_q == '0)                  eff_h = HW'(1);
    else if (32'(grid_height_q) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else                                      eff_h = HW'(grid_height_q);
  end

  // --------------------------------------------------------------------------
  // Command registers and sequencer state
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic [HEAD_W-1:0]  hin_q;
  logic [AW-1:0]      ant_idx_q;
  logic               cmd_ok;
  logic               accept;
  logic               ant_last;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign cmd_ok   = (cmd_i == CMD_STEP) || (cmd_i == CMD_READ) ||
                    ((cmd_i == CMD_PLACE) && (32'(ant_sel_i) < NUM_ANTS));
  assign ant_last = (32'(ant_idx_q) == NUM_ANTS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && cmd_ok) state_d = ST_RD;
      ST_RD:   state_d = ST_WB;
      ST_WB: begin
        if ((cmd_q == CMD_STEP) && !ant_last) state_d = ST_RD;
        else                                  state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Latch the command word; the ant index walks during a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ant_idx_q <= '0;
    end else if (accept && cmd_ok) begin
      ant_idx_q <= (cmd_i == CMD_PLACE) ? AW'(ant_sel_i) : '0;
    end else if ((state_q == ST_WB) && (cmd_q == CMD_STEP) && !ant_last) begin
      ant_idx_q <= ant_idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      hin_q <= heading_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // Ant state
  // --------------------------------------------------------------------------
  logic [XW-1:0]     ant_col_q [NUM_ANTS];
  logic [YW-1:0]     ant_row_q [NUM_ANTS];
  logic [HEAD_W-1:0] ant_hd_q  [NUM_ANTS];
  logic [XW-1:0]     cur_x;
  logic [YW-1:0]     cur_y;
  logic [HEAD_W-1:0] cur_hd;

  assign cur_x  = ant_col_q[ant_idx_q];
  assign cur_y  = ant_row_q[ant_idx_q];
  assign cur_hd = ant_hd_q[ant_idx_q];

  // --------------------------------------------------------------------------
  // Target cell: ant move, clamped place position, or read position
  // --------------------------------------------------------------------------
  logic [XW-1:0] mv_x, tgt_x, tgt_x_q;
  logic [YW-1:0] mv_y, tgt_y, tgt_y_q;
  logic          tgt_in, tgt_in_q;

  always_comb begin
    mv_x = cur_x;
    mv_y = cur_y;
    case (cur_hd)
      HD_POS_X: mv_x = (32'(cur_x) + 32'd1 >= 32'(eff_w)) ? '0 : cur_x + XW'(1);
      HD_NEG_Y: mv_y = (cur_y == '0) ? YW'(32'(eff_h) - 32'd1) : cur_y - YW'(1);
      HD_NEG_X: mv_x = (cur_x == '0) ? XW'(32'(eff_w) - 32'd1) : cur_x - XW'(1);
      default:  mv_y = (32'(cur_y) + 32'd1 >= 32'(eff_h)) ? '0 : cur_y + YW'(1);
    endcase
    // ant left beyond a shrunk grid restarts at the near edge
    if (32'(mv_x) >= 32'(eff_w)) mv_x = '0;
    if (32'(mv_y) >= 32'(eff_h)) mv_y = '0;
  end

  always_comb begin
    tgt_in = 1'b1;
    case (cmd_q)
      CMD_STEP: begin
        tgt_x = mv_x;
        tgt_y = mv_y;
      end
      CMD_PLACE: begin
        tgt_x = (32'(px_q) >= 32'(eff_w)) ? XW'(32'(eff_w) - 32'd1) : XW'(px_q);
        tgt_y = (32'(py_q) >= 32'(eff_h)) ? YW'(32'(eff_h) - 32'd1) : YW'(py_q);
      end
      default: begin
        tgt_x  = XW'(px_q);
        tgt_y  = YW'(py_q);
        tgt_in = (32'(px_q) < 32'(eff_w)) && (32'(py_q) < 32'(eff_h));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      tgt_x_q  <= tgt_x;
      tgt_y_q  <= tgt_y;
      tgt_in_q <= tgt_in;
    end
  end

  // --------------------------------------------------------------------------
  // Cell store: one row of the grid per memory word, valid flop per row
  // --------------------------------------------------------------------------
  logic [MAX_WIDTH-1:0]  row_mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid_q;
  logic [MAX_WIDTH-1:0]  rd_row_q, row_eff, wr_row;
  logic                  rd_valid_q;
  logic                  mem_re, mem_we;
  logic                  cell_old, cell_new;
  logic [HEAD_W-1:0]     hd_new;
  logic                  ant_we;
  logic                  out_load;

  // Outputs of the sequencer
  always_comb begin
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    ant_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_RD: begin
        mem_re = 1'b1;
        ant_we = (cmd_q == CMD_PLACE);
      end
      ST_WB: begin
        mem_we   = (cmd_q == CMD_STEP);
        ant_we   = (cmd_q == CMD_STEP);
        out_load = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    row_eff  = rd_valid_q ? rd_row_q : '0;
    cell_old = row_eff[tgt_x_q];
    cell_new = ~cell_old;
    wr_row   = row_eff;
    wr_row[tgt_x_q] = cell_new;
    hd_new   = cell_new ? cur_hd + HEAD_W'(1) : cur_hd - HEAD_W'(1);
  end

  // Row memory, one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[tgt_y_q] <= wr_row;
    if (mem_re) rd_row_q <= row_mem[tgt_y];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (mem_we) row_valid_q[tgt_y_q] <= 1'b1;
      if (mem_re) rd_valid_q <= row_valid_q[tgt_y];
    end
  end

  // Ant state update: place in the read cycle, step at write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ANTS; i++) begin
        ant_col_q[i] <= '0;
        ant_row_q[i] <= '0;
        ant_hd_q[i]  <= '0;
      end
    end else if (ant_we) begin
      if (state_q == ST_RD) begin
        ant_col_q[ant_idx_q] <= tgt_x;
        ant_row_q[ant_idx_q] <= tgt_y;
        ant_hd_q[ant_idx_q]  <= hin_q;
      end else begin
        ant_col_q[ant_idx_q] <= tgt_x_q;
        ant_row_q[ant_idx_q] <= tgt_y_q;
        ant_hd_q[ant_idx_q]  <= hd_new;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result word register
  // --------------------------------------------------------------------------
  logic               res_valid_q;
  logic [ANT_W-1:0]   res_id_q;
  logic [COORD_W-1:0] res_x_q, res_y_q;
  logic [HEAD_W-1:0]  res_hd_q;
  logic               res_cell_q, res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= out_load;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (cmd_q)
        CMD_STEP: begin
          res_id_q   <= ANT_W'(ant_idx_q);
          res_x_q    <= COORD_W'(tgt_x_q);
          res_y_q    <= COORD_W'(tgt_y_q);
          res_hd_q   <= hd_new;
          res_cell_q <= cell_new;
          res_last_q <= ant_last;
        end
        CMD_PLACE: begin
          res_id_q   <= ANT_W'(ant_idx_q);
          res_x_q    <= COORD_W'(tgt_x_q);
          res_y_q    <= COORD_W'(tgt_y_q);
          res_hd_q   <= hin_q;
          res_cell_q <= cell_old;
          res_last_q <= 1'b1;
        end
        default: begin
          res_id_q   <= '0;
          res_x_q    <= px_q;
          res_y_q    <= py_q;
          res_hd_q   <= '0;
          res_cell_q <= tgt_in_q && cell_old;
          res_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign ant_id_o       = res_id_q;
  assign out_x_o        = res_x_q;
  assign out_y_o        = res_y_q;
  assign out_heading_o  = res_hd_q;
  assign cell_value_o   = res_cell_q;
  assign last_o         = res_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_res_after_wb, clk_i, rst_ni,
      result_valid_o |-> $past(state_q == ST_WB), "result without write-back")
  `ASSERT_CLK(a_last_gap, clk_i, rst_ni,
      (result_valid_o && last_o) |=> !result_valid_o, "result right after last")
  `ASSERT_CLK(a_wb_alternates, clk_i, rst_ni,
      (state_q == ST_WB) |=> (state_q != ST_WB), "back-to-back write-back")
  `ASSERT_CLK(a_write_step_only, clk_i, rst_ni,
      mem_we |-> ((state_q == ST_WB) && (cmd_q == CMD_STEP)), "stray row write")
  `ASSERT_ALWAYS(a_ant_idx_range, clk_i,
      !rst_ni || (32'(ant_idx_q) < NUM_ANTS), "ant index out of range")

endmodule
